### rtl/bfdh_pkg.sv
package bfdh_pkg;

    localparam int FILTER_SIZE = 1024;
    localparam int HASH_W      = $clog2(FILTER_SIZE);

    localparam int DJB_SEED = 5381;
    localparam int DJB_MUL  = 33;
    localparam int SDBM_MUL = 65599;

    localparam logic [HASH_W-1:0] DJB_SEED_MOD = HASH_W'(DJB_SEED % FILTER_SIZE);
    localparam logic [HASH_W-1:0] DJB_MUL_MOD  = HASH_W'(DJB_MUL % FILTER_SIZE);
    localparam logic [HASH_W-1:0] SDBM_MUL_MOD = HASH_W'(SDBM_MUL % FILTER_SIZE);

    localparam int HC_W   = 4;
    localparam int CNT_W  = 3;
    localparam logic [HC_W-1:0] HASH_COUNT_RESET = 4'd2;
    localparam logic [HC_W-1:0] HASH_COUNT_MIN   = 4'd1;
    localparam logic [HC_W-1:0] HASH_COUNT_MAX   = 4'd8;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [ADDR_W-3:0] REG_HASH_COUNT = '0;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    localparam int JOB_DEPTH = 2;
    localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
    localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

    typedef struct packed {
        logic       op;
        logic [7:0] key_byte;
        logic       has_byte;
        logic       last;
    } t_in_word;

    typedef struct packed {
        logic maybe_present;
        logic was_check;
    } t_out_word;

    typedef struct packed {
        logic              op;
        logic [HASH_W-1:0] h1;
        logic [HASH_W-1:0] h2;
        logic [CNT_W-1:0]  cnt_m1;
    } t_job;

    typedef struct packed {
        logic valid;
        logic ready;
    } t_q_ctl;

endpackage

### rtl/bloom_filter_double_hash_unit.sv
// Channel  Ports                              Word
// -------  ---------------------------------  ----------------------------------------
// input    i_data, push, full                 op, key_byte, has_byte, last
// result   o_data, empty, pop                 maybe_present, was_check
// config   psel, penable, pwrite, paddr,      hash_count at 0x0, prdata reads back
//          pwdata, prdata, pready
//
// Key bytes are taken one per cycle while full is low; each last word queues a
// probe job (2 deep). A job runs hash_count (clamped to 1..8) probes in the back
// end, one bit-store access per probe.
// After reset the 1024-bit store is cleared with full held high.
// full is high while clearing or the job queue is full; a waiting result holds
// the back end from starting the next job until it is popped.
module bloom_filter_double_hash_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bfdh_pkg::t_in_word                  i_data,
    input  logic                                push,
    output logic                                full,
    output bfdh_pkg::t_out_word                 o_data,
    output logic                                empty,
    input  logic                                pop,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bfdh_pkg::ADDR_W-1:0]         paddr,
    input  logic [bfdh_pkg::DATA_W-1:0]         pwdata,
    output logic [bfdh_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);
    import bfdh_pkg::*;

    logic [HC_W-1:0] r_hash_count;
    logic            reg_sel;
    logic            accept;
    logic            job_push, job_pop, clearing;
    t_job            fe_job, q_job;
    t_q_ctl          q_ctl;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[ADDR_W-1:2] == REG_HASH_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_count <= HASH_COUNT_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_hash_count <= pwdata[HC_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_sel) begin
            prdata = DATA_W'(r_hash_count);
        end
    end

    assign full   = clearing || !q_ctl.ready;
    assign accept = push && !full;

    bfdh_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_word       (i_data),
        .i_hash_count (r_hash_count),
        .o_job_push   (job_push),
        .o_job        (fe_job)
    );

    bfdh_job_fifo u_job_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (fe_job),
        .i_pop   (job_pop),
        .o_ctl   (q_ctl),
        .o_job   (q_job)
    );

    bfdh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_ctl.valid),
        .i_job       (q_job),
        .o_job_pop   (job_pop),
        .o_clearing  (clearing),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_word      (o_data)
    );

endmodule

### rtl/bfdh_front.sv
module bfdh_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  bfdh_pkg::t_in_word       i_word,
    input  logic [bfdh_pkg::HC_W-1:0] i_hash_count,
    output logic                     o_job_push,
    output bfdh_pkg::t_job           o_job
);
    import bfdh_pkg::*;

    logic [HASH_W-1:0] r_h1, n_h1;
    logic [HASH_W-1:0] r_h2, n_h2;
    logic [HASH_W-1:0] upd_h1, upd_h2;
    logic [HC_W-1:0]   cnt;

    always_comb begin
        upd_h1 = HASH_W'(r_h1 * DJB_MUL_MOD + HASH_W'(i_word.key_byte));
        upd_h2 = HASH_W'(r_h2 * SDBM_MUL_MOD + HASH_W'(i_word.key_byte));
        if (!i_word.has_byte) begin
            upd_h1 = r_h1;
            upd_h2 = r_h2;
        end
        n_h1 = r_h1;
        n_h2 = r_h2;
        if (i_accept) begin
            if (i_word.last) begin
                n_h1 = DJB_SEED_MOD;
                n_h2 = '0;
            end else begin
                n_h1 = upd_h1;
                n_h2 = upd_h2;
            end
        end
        cnt = i_hash_count;
        if (i_hash_count < HASH_COUNT_MIN) begin
            cnt = HASH_COUNT_MIN;
        end else if (i_hash_count > HASH_COUNT_MAX) begin
            cnt = HASH_COUNT_MAX;
        end
        o_job.op     = i_word.op;
        o_job.h1     = upd_h1;
        o_job.h2     = upd_h2;
        o_job.cnt_m1 = CNT_W'(cnt - HC_W'(1));
        o_job_push   = i_accept && i_word.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h1 <= DJB_SEED_MOD;
            r_h2 <= '0;
        end else begin
            r_h1 <= n_h1;
            r_h2 <= n_h2;
        end
    end

endmodule

### rtl/bfdh_job_fifo.sv
module bfdh_job_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  bfdh_pkg::t_job   i_job,
    input  logic             i_pop,
    output bfdh_pkg::t_q_ctl o_ctl,
    output bfdh_pkg::t_job   o_job
);
    import bfdh_pkg::*;

    t_job                 r_mem [JOB_DEPTH];
    logic [JOB_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [JOB_CNT_W-1:0] r_count;
    logic                 do_push, do_pop;

    assign o_ctl.valid = (r_count != '0);
    assign o_ctl.ready = (r_count != JOB_CNT_W'(JOB_DEPTH));
    assign do_push     = i_push && o_ctl.ready;
    assign do_pop      = i_pop && o_ctl.valid;
    assign o_job       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= JOB_PTR_W'(r_wr_ptr + 1'b1);
            end
            if (do_pop) begin
                r_rd_ptr <= JOB_PTR_W'(r_rd_ptr + 1'b1);
            end
            if (do_push && !do_pop) begin
                r_count <= JOB_CNT_W'(r_count + 1'b1);
            end else if (do_pop && !do_push) begin
                r_count <= JOB_CNT_W'(r_count - 1'b1);
            end
        end
    end

endmodule

### rtl/bfdh_back.sv
module bfdh_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  bfdh_pkg::t_job      i_job,
    output logic                o_job_pop,
    output logic                o_clearing,
    output logic                o_empty,
    input  logic                i_pop,
    output bfdh_pkg::t_out_word o_word
);
    import bfdh_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_PROBE = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [HASH_W-1:0] r_clr_addr, n_clr_addr;
    t_job              r_job, n_job;
    logic [HASH_W-1:0] r_pos, n_pos;
    logic [CNT_W-1:0]  r_step, n_step;
    logic              r_all_set, n_all_set;
    logic              r_rd_pend, n_rd_pend;
    logic              r_out_valid, n_out_valid;
    t_out_word         r_out, n_out;

    logic              mem [FILTER_SIZE];
    logic              r_rdata;
    logic              wr_en, wr_data;
    logic [HASH_W-1:0] wr_addr;
    logic              fin;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[r_pos];
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_job       = r_job;
        n_pos       = r_pos;
        n_step      = r_step;
        n_all_set   = r_all_set;
        n_rd_pend   = r_rd_pend;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        wr_en       = 1'b0;
        wr_data     = 1'b0;
        wr_addr     = r_pos;
        o_job_pop   = 1'b0;
        fin         = r_all_set && (!r_rd_pend || r_rdata);
        if (i_pop && r_out_valid) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_CLEAR: begin
                wr_en      = 1'b1;
                wr_addr    = r_clr_addr;
                n_clr_addr = HASH_W'(r_clr_addr + 1'b1);
                if (r_clr_addr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                n_rd_pend = 1'b0;
                if (i_job_valid && !r_out_valid) begin
                    o_job_pop = 1'b1;
                    n_job     = i_job;
                    n_pos     = i_job.h1;
                    n_step    = '0;
                    n_all_set = 1'b1;
                    n_state   = ST_PROBE;
                end
            end
            ST_PROBE: begin
                n_all_set = fin;
                if (r_job.op == OP_ADD) begin
                    wr_en   = 1'b1;
                    wr_data = 1'b1;
                end
                n_rd_pend = (r_job.op == OP_CHECK);
                n_pos     = HASH_W'(r_pos + r_job.h2);
                n_step    = CNT_W'(r_step + 1'b1);
                if (r_step == r_job.cnt_m1) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_out_valid         = 1'b1;
                n_out.was_check     = (r_job.op == OP_CHECK);
                n_out.maybe_present = (r_job.op == OP_CHECK) && fin;
                n_rd_pend           = 1'b0;
                n_state             = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
        r_job     <= n_job;
        r_pos     <= n_pos;
        r_step    <= n_step;
        r_all_set <= n_all_set;
        r_out     <= n_out;
    end

    assign o_clearing = (r_state == ST_CLEAR);
    assign o_empty    = !r_out_valid;
    assign o_word     = r_out;

endmodule

### sim/testbench.sv
module testbench;

    import bfdh_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int POOL_MAX = 32;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AT_RESULT = 120;
    localparam logic [ADDR_W-1:0] HC_ADDR = {REG_HASH_COUNT, 2'b00};
    localparam logic [ADDR_W-1:0] SPARE_ADDR = 3'd4;

    typedef struct packed {
        logic       op;
        logic [7:0] key_byte;
        logic       has_byte;
        logic       last;
        logic       typed;
        logic       maybe_present;
        logic       was_check;
    } t_row;

    typedef struct packed {
        logic [63:0] bytes;
        logic [3:0]  len;
    } t_key;

    // typed answers: empty filter misses, adds answer 0/0, a key just added hits
    localparam int N_ROWS = 15;
    localparam t_row DIRECTED [N_ROWS] = '{
        '{OP_CHECK, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1},
        '{OP_ADD,   8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
        '{OP_CHECK, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1},
        '{OP_CHECK, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_ADD,   8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
        '{OP_ADD,   8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_ADD,   8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_CHECK, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1},
        '{OP_ADD,   8'hAA, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
        '{OP_CHECK, 8'hAA, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1},
        '{OP_CHECK, 8'h55, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
        '{OP_CHECK, 8'h01, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_CHECK, 8'h80, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
        '{OP_CHECK, 8'h7F, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_CHECK, 8'hFE, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0}
    };

    logic                i_clk;
    logic                i_rst_n;
    t_in_word            i_data;
    logic                push;
    logic                full;
    t_out_word           o_data;
    logic                empty;
    logic                pop;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    bloom_filter_double_hash_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (i_data),
        .push    (push),
        .full    (full),
        .o_data  (o_data),
        .empty   (empty),
        .pop     (pop),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    logic [HASH_W-1:0] djb_acc;
    logic [HASH_W-1:0] sdbm_acc;
    logic [HC_W-1:0]   hash_count_reg;
    bit                filter_store [FILTER_SIZE];

    t_out_word pending_answers [$];
    t_key      added_keys [$];
    int        mismatch_count;
    int        words_sent;
    int        answers_seen;
    int        cycle_count;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic hash_and_probe(input t_in_word w, output bit produces,
                                  output t_out_word ans);
        int unsigned       probes;
        logic [HASH_W-1:0] pos;
        bit                all_set;
        produces = 1'b0;
        ans = '0;
        all_set = 1'b1;
        if (w.has_byte) begin
            djb_acc  = HASH_W'(djb_acc * DJB_MUL + w.key_byte);
            sdbm_acc = HASH_W'(sdbm_acc * SDBM_MUL + w.key_byte);
        end
        if (!w.last) begin
            return;
        end
        if (hash_count_reg < HASH_COUNT_MIN) begin
            probes = 32'(HASH_COUNT_MIN);
        end else if (hash_count_reg > HASH_COUNT_MAX) begin
            probes = 32'(HASH_COUNT_MAX);
        end else begin
            probes = 32'(hash_count_reg);
        end
        pos = djb_acc;
        for (int i = 0; i < probes; i++) begin
            if (w.op == OP_ADD) begin
                filter_store[pos] = 1'b1;
            end else if (!filter_store[pos]) begin
                all_set = 1'b0;
            end
            pos = pos + sdbm_acc;
        end
        ans.maybe_present = (w.op == OP_CHECK) && all_set;
        ans.was_check = w.op;
        produces = 1'b1;
        djb_acc = DJB_SEED_MOD;
        sdbm_acc = '0;
    endtask

    task automatic send_word(input t_in_word w, input bit typed, input t_out_word typed_ans);
        bit        produces;
        t_out_word ans;
        bit        steady;
        steady = (words_sent >= 700) && (words_sent < 900);
        if (!steady && $urandom_range(99) < 27) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_data <= w;
        do @(posedge i_clk); while (full);
        hash_and_probe(w, produces, ans);
        if (produces) begin
            pending_answers.push_back(typed ? typed_ans : ans);
        end
        if (w.has_byte || w.last) begin
            words_sent++;
        end
    endtask

    task automatic send_noise();
        t_in_word w;
        w.op = 1'($urandom_range(1));
        w.key_byte = 8'($urandom_range(255));
        w.has_byte = 1'b0;
        w.last = 1'b0;
        send_word(w, 1'b0, '0);
    endtask

    task automatic send_key(input t_key k, input logic op);
        t_in_word w;
        bit       byteless_end;
        byteless_end = (k.len == 0) || ($urandom_range(9) == 0);
        for (int i = 0; i < k.len; i++) begin
            if ($urandom_range(9) == 0) begin
                send_noise();
            end
            w.op = (i == k.len - 1 && !byteless_end) ? op : logic'($urandom_range(1));
            w.key_byte = k.bytes[8*i +: 8];
            w.has_byte = 1'b1;
            w.last = (i == k.len - 1) && !byteless_end;
            send_word(w, 1'b0, '0);
        end
        if (byteless_end) begin
            w.op = op;
            w.key_byte = 8'($urandom_range(255));
            w.has_byte = 1'b0;
            w.last = 1'b1;
            send_word(w, 1'b0, '0);
        end
    endtask

    task automatic run_keys(input int word_budget);
        int   stop_at;
        int   pick;
        t_key k;
        logic op;
        stop_at = words_sent + word_budget;
        while (words_sent < stop_at) begin
            pick = $urandom_range(99);
            op = logic'($urandom_range(1));
            k.bytes = {$urandom, $urandom};
            k.len = 4'($urandom_range(1, 8));
            if (pick < 30 && added_keys.size() != 0) begin
                k = added_keys[$urandom_range(added_keys.size() - 1)];
                op = OP_CHECK;
            end else if (pick < 40) begin
                k.len = 0;
            end else if (pick < 48) begin
                send_noise();
                continue;
            end
            if (op == OP_ADD) begin
                added_keys.push_back(k);
                if (added_keys.size() > POOL_MAX) begin
                    void'(added_keys.pop_front());
                end
            end
            send_key(k, op);
        end
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr[ADDR_W-1:2] == REG_HASH_COUNT) begin
            hash_count_reg = value[HC_W-1:0];
        end
    endtask

    task automatic check_hash_count();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= HC_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[HC_W-1:0] !== hash_count_reg) begin
            $error("hash_count: expected %0d, got %0d", hash_count_reg, prdata[HC_W-1:0]);
            mismatch_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_phase(input logic [HC_W-1:0] hc, input int word_budget);
        wait_idle();
        reg_write(HC_ADDR, DATA_W'(hc));
        check_hash_count();
        run_keys(word_budget);
    endtask

    // result side: random pop with a steady stretch, one long hold-off to fill the block
    initial begin
        int  hold_left;
        bit  held;
        bit  steady;
        t_out_word want;
        hold_left = 0;
        held = 1'b0;
        pop <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                answers_seen++;
                if (pending_answers.size() == 0) begin
                    $error("unexpected result word: maybe_present %0d was_check %0d",
                           o_data.maybe_present, o_data.was_check);
                    mismatch_count++;
                end else begin
                    want = pending_answers.pop_front();
                    if (o_data.maybe_present !== want.maybe_present) begin
                        $error("maybe_present: expected %0d, got %0d",
                               want.maybe_present, o_data.maybe_present);
                        mismatch_count++;
                    end
                    if (o_data.was_check !== want.was_check) begin
                        $error("was_check: expected %0d, got %0d",
                               want.was_check, o_data.was_check);
                        mismatch_count++;
                    end
                end
            end
            if (!held && answers_seen >= HOLD_AT_RESULT) begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            steady = (answers_seen >= 300) && (answers_seen < 420);
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= steady || ($urandom_range(99) >= 21);
            end
        end
    end

    initial begin
        t_in_word  w;
        t_out_word a;
        mismatch_count = 0;
        words_sent = 0;
        answers_seen = 0;
        djb_acc = DJB_SEED_MOD;
        sdbm_acc = '0;
        hash_count_reg = HASH_COUNT_RESET;
        i_rst_n <= 1'b0;
        i_data <= '0;
        push <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        check_hash_count();
        for (int r = 0; r < N_ROWS; r++) begin
            w.op = DIRECTED[r].op;
            w.key_byte = DIRECTED[r].key_byte;
            w.has_byte = DIRECTED[r].has_byte;
            w.last = DIRECTED[r].last;
            a.maybe_present = DIRECTED[r].maybe_present;
            a.was_check = DIRECTED[r].was_check;
            send_word(w, DIRECTED[r].typed, a);
        end
        run_keys(150);

        run_phase(4'd1, 170);
        run_phase(4'd8, 170);
        run_phase(4'd0, 150);
        run_phase(4'd15, 150);
        wait_idle();
        reg_write(SPARE_ADDR, 32'hFFFF_FFF3);
        check_hash_count();
        run_keys(60);
        run_phase(4'd9, 150);
        run_phase(4'd3, 150);
        run_phase(4'd5, 150);
        run_phase(HC_W'($urandom_range(0, 15)), 100);

        wait_idle();
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_answers.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### sim.f
rtl/bfdh_pkg.sv
rtl/bfdh_front.sv
rtl/bfdh_job_fifo.sv
rtl/bfdh_back.sv
rtl/bloom_filter_double_hash_unit.sv
sim/testbench.sv
